[design/b85enc_pkg.sv]
// ----------------------------------------------------------------------------
// b85enc_pkg
// Shared constants and types for the base-85 byte encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b85enc_pkg;

    localparam int unsigned B85_RADIX  = 85;
    localparam int unsigned B85_OFFSET = 33;
    localparam int unsigned B85_DIGITS = 5;

    // floor(v / 85) == (v * B85_RECIP) >> B85_SHIFT for every 32-bit v
    localparam logic [31:0] B85_RECIP = 32'd3233857729;
    localparam int unsigned B85_SHIFT = 38;
    localparam int unsigned PROD_W    = 64;
    localparam int unsigned QUOT_W    = PROD_W - B85_SHIFT;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_DIV,
        ST_EMIT
    } b85_state_t;

    typedef struct packed {
        logic load;   // take a new 32-bit word
        logic prime;  // first multiply by the reciprocal
        logic step;   // peel off one digit
    } div_ctrl_t;

endpackage

`default_nettype wire

[design/b85enc_div_unit.sv]
// ----------------------------------------------------------------------------
// b85enc_div_unit
// Shared divide-by-85 step: reciprocal multiply, then quotient and remainder.
// One digit per step, least significant digit first.
// ----------------------------------------------------------------------------
`default_nettype none

module b85enc_div_unit
    import b85enc_pkg::*;
(
    input  wire logic        aclk,
    input  wire div_ctrl_t   ctrl,
    input  wire logic [31:0] load_word,
    output logic      [6:0]  digit_char
);

    logic [31:0]       v_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [QUOT_W-1:0] quot;
    logic [31:0]       mul_a;
    logic [PROD_W-1:0] prod_next;
    logic [31:0]       rem_full;

    assign quot      = prod_reg[PROD_W-1 -: QUOT_W];
    assign mul_a     = ctrl.prime ? v_reg : 32'(quot);
    assign prod_next = PROD_W'(mul_a) * PROD_W'(B85_RECIP);

    // remainder is below 85, so the low seven bits carry it whole
    assign rem_full   = v_reg - 32'(quot) * 32'(B85_RADIX);
    assign digit_char = rem_full[6:0] + 7'(B85_OFFSET);

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            v_reg <= load_word;
        end else if (ctrl.step) begin
            v_reg <= 32'(quot);
        end
        if (ctrl.prime || ctrl.step) begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

[design/base85_byte_encoder.sv]
// ----------------------------------------------------------------------------
// base85_byte_encoder
// Packs bytes big-endian into groups of four and sends each group as five
// base-85 characters (digit + 33); a partial last group of k bytes sends k+1.
// ----------------------------------------------------------------------------
//
//  channel  dir  data (lsb up)         sideband
//  s_*      in   [7:0] data_byte       tlast = final_byte
//  m_*      out  [6:0] out_char, [7]=0 tlast = run_last
//
//  A byte that only joins the open group is taken; the state stays idle.
//  A byte closing a group: accept, prime and five divide steps, then one
//  character per cycle while m_tready is high; one multiply unit sets this.
//  s_tready is low from accept until the last character's transfer.
//  m_tready low holds the current character; no input is taken meanwhile.
//  aresetn is synchronous; it empties the group and returns to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module base85_byte_encoder
    import b85enc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,   // [6:0] out_char, [7] zero
    output logic            m_tlast
);

    b85_state_t  state_reg, state_next;
    logic [23:0] group_reg, group_next;
    logic [1:0]  fill_reg, fill_next;
    logic [2:0]  n_reg, n_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [6:0]  char_reg [B85_DIGITS];
    logic [31:0] load_word;
    logic [6:0]  digit_char;
    div_ctrl_t   ctrl;

    b85enc_div_unit u_div (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .load_word  (load_word),
        .digit_char (digit_char)
    );

    // zero-fill the missing low bytes of a partial group
    always_comb begin
        unique case (fill_reg)
            2'd0:    load_word = {s_tdata, 24'd0};
            2'd1:    load_word = {group_reg[7:0], s_tdata, 16'd0};
            2'd2:    load_word = {group_reg[15:0], s_tdata, 8'd0};
            default: load_word = {group_reg, s_tdata};
        endcase
    end

    always_comb begin
        state_next = state_reg;
        group_next = group_reg;
        fill_next  = fill_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        ctrl       = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (fill_reg != 2'd3 && !s_tlast) begin
                        group_next = {group_reg[15:0], s_tdata};
                        fill_next  = fill_reg + 2'd1;
                    end else begin
                        ctrl.load  = 1'b1;
                        n_next     = 3'(fill_reg) + 3'd2;
                        group_next = '0;
                        fill_next  = '0;
                        state_next = ST_PRIME;
                    end
                end
            end
            ST_PRIME: begin
                ctrl.prime = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                ctrl.step = 1'b1;
                if (cnt_reg == 3'(B85_DIGITS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (m_tlast) begin
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tdata = {1'b0, char_reg[cnt_reg]};
    assign m_tlast = (cnt_reg == n_reg - 3'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            group_reg <= '0;
            fill_reg  <= '0;
            cnt_reg   <= '0;
            n_reg     <= 3'(B85_DIGITS);
        end else begin
            state_reg <= state_next;
            group_reg <= group_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
        end
    end

    // digits come out least significant first: fill the store from the top
    always_ff @(posedge aclk) begin
        if (ctrl.step) begin
            char_reg[3'(B85_DIGITS - 1) - cnt_reg] <= digit_char;
        end
    end

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output open together");

    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:0] >= 7'd33 && m_tdata[6:0] <= 7'd117 && !m_tdata[7]))
        else $error("character outside base-85 range");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (n_reg >= 3'd2 && n_reg <= 3'(B85_DIGITS) && cnt_reg < n_reg))
        else $error("character count out of range");

    a_back_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && fill_reg == 2'd0))
        else $error("run end did not return to an empty group");
`endif

endmodule

`default_nettype wire
